// ----- rtl/battery_level_monitor_led_blinker_core_assert.svh -----
// assertion macros for the battery monitor core
// expects clk and arst_n in the scope of each use
`ifndef BATTERY_LEVEL_MONITOR_LED_BLINKER_CORE_ASSERT_SVH
`define BATTERY_LEVEL_MONITOR_LED_BLINKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property checked while out of reset
`define BLM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("battery monitor assertion failed");
// condition that must never be seen out of reset
`define BLM_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("battery monitor forbidden condition");
`else
`define BLM_ASSERT(lbl, prop)
`define BLM_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ----- rtl/blm_pkg.sv -----
// shared types, constants and register map of the battery monitor core
// no dependencies
package blm_pkg;

	localparam int NOW_W   = 32;
	localparam int ADC_W   = 10;
	localparam int OFS_W   = 10;
	localparam int THR_W   = 16;
	localparam int FRAC_W  = 10;
	// adc * 53000 + offset * 1024 stays below 2^27
	localparam int VOLT_W  = 27;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [15:0] ADC_SCALE = 16'd53000;

	localparam logic [NOW_W-1:0] SAMPLE_PERIOD = 32'd100;
	localparam logic [NOW_W-1:0] PER_NORMAL    = 32'd200;
	localparam logic [NOW_W-1:0] PER_HIGH      = 32'd250;
	localparam logic [NOW_W-1:0] PER_LOW_ON    = 32'd500;
	localparam logic [NOW_W-1:0] PER_LOW_OFF   = 32'd1500;
	localparam logic [NOW_W-1:0] PER_VERY_LOW  = 32'd1000;

	localparam logic [THR_W-1:0] RST_HIGH_12     = 16'd16600;
	localparam logic [THR_W-1:0] RST_LOW_12      = 16'd11000;
	localparam logic [THR_W-1:0] RST_VERY_LOW_12 = 16'd9700;
	localparam logic [THR_W-1:0] RST_HIGH_24     = 16'd31500;
	localparam logic [THR_W-1:0] RST_LOW_24      = 16'd24000;
	localparam logic [THR_W-1:0] RST_VERY_LOW_24 = 16'd22000;

	typedef enum logic [1:0] {
		CLS_NORMAL   = 2'd0,
		CLS_HIGH     = 2'd1,
		CLS_LOW      = 2'd2,
		CLS_VERY_LOW = 2'd3
	} cls_t;

	typedef enum logic [2:0] {
		REG_SUPPLY_IS_24V  = 3'd0,
		REG_OFFSET_MV      = 3'd1,
		REG_HIGH_12_MV     = 3'd2,
		REG_LOW_12_MV      = 3'd3,
		REG_VERY_LOW_12_MV = 3'd4,
		REG_HIGH_24_MV     = 3'd5,
		REG_LOW_24_MV      = 3'd6,
		REG_VERY_LOW_24_MV = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic             supply_is_24v;
		logic [OFS_W-1:0] offset_mv;
		logic [THR_W-1:0] high_12_mv;
		logic [THR_W-1:0] low_12_mv;
		logic [THR_W-1:0] very_low_12_mv;
		logic [THR_W-1:0] high_24_mv;
		logic [THR_W-1:0] low_24_mv;
		logic [THR_W-1:0] very_low_24_mv;
	} cfg_t;

	// registered call between the front stage and the update stage
	typedef struct packed {
		logic              valid;
		logic [NOW_W-1:0]  now_ms;
		logic [VOLT_W-1:0] volt;
	} item_t;

endpackage

// ----- rtl/blm_ifs.sv -----
// valid/ready channel interfaces for calls and status results
// depends on blm_pkg
interface blm_call_if import blm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NOW_W-1:0] now_ms;
	logic [ADC_W-1:0] adc_sample;

	modport source(output valid, output now_ms, output adc_sample, input ready);
	modport sink(input valid, input now_ms, input adc_sample, output ready);
endinterface

interface blm_status_if ();
	logic       valid;
	logic       ready;
	logic [1:0] battery_class;
	logic       led_on;

	modport source(output valid, output battery_class, output led_on, input ready);
	modport sink(input valid, input battery_class, input led_on, output ready);
endinterface

// ----- rtl/battery_level_monitor_led_blinker_core.sv -----
// battery level monitor with warning led blinker, top level
// latency: a call beat passes the input register and then the status register before its status shows
// throughput: one call per cycle while status beats are taken; the deadline and class update is combinational
// reset: arst_n clears class, deadlines, led and blink phase, and loads threshold defaults
// depends on blm_pkg, blm_ifs, blm_regs, blm_front, blm_update and the assertion header
`include "battery_level_monitor_led_blinker_core_assert.svh"
module battery_level_monitor_led_blinker_core import blm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	blm_call_if.sink           call,
	blm_status_if.source       status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t  cfg;
	item_t item_s1;
	logic  adv;

	blm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	blm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.call      (call),
		.offset_mv (cfg.offset_mv),
		.adv       (adv),
		.item_s1   (item_s1)
	);

	blm_update u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.status  (status),
		.adv     (adv)
	);

	// a new status beat only comes from a registered call
	`BLM_ASSERT(a_status_from_call, $rose(status.valid) |-> $past(item_s1.valid))
	// a stalled registered call keeps its time stamp
	`BLM_ASSERT(a_stall_holds, item_s1.valid && status.valid && !status.ready |=> item_s1.valid && $stable(item_s1.now_ms))
	// backpressure on calls only while a call sits in the input register
	`BLM_ASSERT_NEVER(a_ready_low_empty, !call.ready && !item_s1.valid)

endmodule

// ----- rtl/blm_regs.sv -----
// configuration registers behind the apb-style port
// depends on blm_pkg
module blm_regs import blm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.supply_is_24v  <= 1'b0;
			cfg_q.offset_mv      <= '0;
			cfg_q.high_12_mv     <= RST_HIGH_12;
			cfg_q.low_12_mv      <= RST_LOW_12;
			cfg_q.very_low_12_mv <= RST_VERY_LOW_12;
			cfg_q.high_24_mv     <= RST_HIGH_24;
			cfg_q.low_24_mv      <= RST_LOW_24;
			cfg_q.very_low_24_mv <= RST_VERY_LOW_24;
		end else if (wr_en) begin
			case (idx)
				REG_SUPPLY_IS_24V:  cfg_q.supply_is_24v  <= pwdata[0];
				REG_OFFSET_MV:      cfg_q.offset_mv      <= pwdata[OFS_W-1:0];
				REG_HIGH_12_MV:     cfg_q.high_12_mv     <= pwdata[THR_W-1:0];
				REG_LOW_12_MV:      cfg_q.low_12_mv      <= pwdata[THR_W-1:0];
				REG_VERY_LOW_12_MV: cfg_q.very_low_12_mv <= pwdata[THR_W-1:0];
				REG_HIGH_24_MV:     cfg_q.high_24_mv     <= pwdata[THR_W-1:0];
				REG_LOW_24_MV:      cfg_q.low_24_mv      <= pwdata[THR_W-1:0];
				REG_VERY_LOW_24_MV: cfg_q.very_low_24_mv <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SUPPLY_IS_24V:  prdata = PDATA_W'(cfg_q.supply_is_24v);
			REG_OFFSET_MV:      prdata = PDATA_W'(cfg_q.offset_mv);
			REG_HIGH_12_MV:     prdata = PDATA_W'(cfg_q.high_12_mv);
			REG_LOW_12_MV:      prdata = PDATA_W'(cfg_q.low_12_mv);
			REG_VERY_LOW_12_MV: prdata = PDATA_W'(cfg_q.very_low_12_mv);
			REG_HIGH_24_MV:     prdata = PDATA_W'(cfg_q.high_24_mv);
			REG_LOW_24_MV:      prdata = PDATA_W'(cfg_q.low_24_mv);
			REG_VERY_LOW_24_MV: prdata = PDATA_W'(cfg_q.very_low_24_mv);
			default:            prdata = '0;
		endcase
	end

endmodule

// ----- rtl/blm_front.sv -----
// input register: takes a call beat and registers it with its voltage
// in 1/1024 mV units; depends on blm_pkg and blm_ifs
module blm_front import blm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	blm_call_if.sink         call,
	input  logic [OFS_W-1:0] offset_mv,
	input  logic             adv,
	output item_t            item_s1
);

	logic              valid_s1;
	logic [NOW_W-1:0]  now_s1;
	logic [VOLT_W-1:0] volt_s1;
	logic [VOLT_W-1:0] volt;
	logic              take;

	assign call.ready = !valid_s1 || adv;
	assign take       = call.valid && call.ready;

	// exact voltage: adc * 53000 + offset * 1024
	assign volt = VOLT_W'(call.adc_sample) * VOLT_W'(ADC_SCALE)
	            + VOLT_W'({offset_mv, {FRAC_W{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (call.ready) begin
			valid_s1 <= call.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			now_s1  <= call.now_ms;
			volt_s1 <= volt;
		end
	end

	assign item_s1.valid  = valid_s1;
	assign item_s1.now_ms = now_s1;
	assign item_s1.volt   = volt_s1;

endmodule

// ----- rtl/blm_update.sv -----
// deadline checks, classification, led pattern and the status register
// depends on blm_pkg and blm_ifs
module blm_update import blm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item_s1,
	input  cfg_t       cfg,
	blm_status_if.source status,
	output logic       adv
);

	logic             out_valid_q;
	cls_t             class_q;
	logic             led_q;
	logic             phase_q;
	logic [NOW_W-1:0] sample_dl_q;
	logic [NOW_W-1:0] led_dl_q;

	logic [VOLT_W-1:0] hi_v, lo_v, vlo_v;
	logic [THR_W-1:0]  hi_t, lo_t, vlo_t;
	logic              sample_fire, led_fire;
	cls_t              class_new;
	logic              led_new, phase_new;
	logic [NOW_W-1:0]  period;

	assign adv = item_s1.valid && (!out_valid_q || status.ready);

	assign hi_t  = cfg.supply_is_24v ? cfg.high_24_mv     : cfg.high_12_mv;
	assign lo_t  = cfg.supply_is_24v ? cfg.low_24_mv      : cfg.low_12_mv;
	assign vlo_t = cfg.supply_is_24v ? cfg.very_low_24_mv : cfg.very_low_12_mv;
	assign hi_v  = VOLT_W'({hi_t, {FRAC_W{1'b0}}});
	assign lo_v  = VOLT_W'({lo_t, {FRAC_W{1'b0}}});
	assign vlo_v = VOLT_W'({vlo_t, {FRAC_W{1'b0}}});

	assign sample_fire = sample_dl_q < item_s1.now_ms;
	assign led_fire    = led_dl_q < item_s1.now_ms;

	// earlier rules win; a value on a threshold keeps the old class
	always_comb begin
		class_new = class_q;
		if (sample_fire) begin
			if (item_s1.volt < hi_v && item_s1.volt > lo_v) begin
				class_new = CLS_NORMAL;
			end else if (item_s1.volt < vlo_v) begin
				class_new = CLS_VERY_LOW;
			end else if (item_s1.volt < lo_v) begin
				class_new = CLS_LOW;
			end else if (item_s1.volt > hi_v) begin
				class_new = CLS_HIGH;
			end
		end
	end

	always_comb begin
		led_new   = led_q;
		phase_new = phase_q;
		period    = '0;
		case (class_new)
			CLS_NORMAL: begin
				led_new = 1'b0;
				period  = PER_NORMAL;
			end
			CLS_HIGH: begin
				led_new = !led_q;
				period  = PER_HIGH;
			end
			CLS_LOW: begin
				led_new   = !phase_q;
				phase_new = !phase_q;
				period    = phase_q ? PER_LOW_OFF : PER_LOW_ON;
			end
			default: begin
				led_new = 1'b1;
				period  = PER_VERY_LOW;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			class_q     <= CLS_NORMAL;
			led_q       <= 1'b0;
			phase_q     <= 1'b0;
			sample_dl_q <= '0;
			led_dl_q    <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				class_q     <= class_new;
				if (sample_fire) begin
					sample_dl_q <= item_s1.now_ms + SAMPLE_PERIOD;
				end
				if (led_fire) begin
					led_q    <= led_new;
					phase_q  <= phase_new;
					led_dl_q <= led_dl_q + period;
				end
			end else if (status.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.valid         = out_valid_q;
	assign status.battery_class = class_q;
	assign status.led_on        = led_q;

endmodule
